/* hdl/rna_pkg.sv */
// ----------------------------------------------------------------------------
// rna_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rna_pkg;

  localparam int OperandWidthDefault = 32;
  localparam int ResultWidth = 64;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_EQ   = 3'd4,
    ACT_LT   = 3'd5,
    ACT_NORM = 3'd6,
    ACT_NOP  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD_INIT,
    ST_DIV,
    ST_GCD_STEP,
    ST_QN,
    ST_QD,
    ST_FIN
  } state_t;

endpackage

/* hdl/rational_number_alu_top.sv */
// ----------------------------------------------------------------------------
// rational_number_alu_top
// Rational arithmetic unit: add, subtract, multiply, divide, compare and
// GCD reduction of 32-bit fractions.
// ----------------------------------------------------------------------------
// Usage: drive in_action and the four operand ports and pulse start while
// busy is low; the operands are captured on that edge and busy rises.
// The result appears on out_result_numerator, out_result_denominator and
// out_flag for one cycle, marked by out_valid; busy falls with it, and the
// next command may be transferred in that same cycle.
// Sequencing: all products come from one shift-add multiplier, one product
// at a time; add, subtract and the compares form three products and then
// combine them, multiply and divide form two, and the unused action (NOP)
// goes straight to the finish state.
// Normalize runs Euclid on a restoring divider that retires one quotient bit
// per cycle: one division per remainder step, then two more divisions that
// divide numerator and denominator by the GCD. A zero denominator skips
// Euclid and goes straight to the finish state.
// One command is in flight at a time. Reset returns the block to idle and
// drops any command in progress. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module rational_number_alu_top #(
  parameter int OPERAND_WIDTH = rna_pkg::OperandWidthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic signed [31:0] in_a_numerator,
  input  logic signed [31:0] in_a_denominator,
  input  logic signed [31:0] in_b_numerator,
  input  logic signed [31:0] in_b_denominator,
  output logic        out_valid,
  output logic signed [63:0] out_result_numerator,
  output logic signed [63:0] out_result_denominator,
  output logic        out_flag
);

  localparam int W  = OPERAND_WIDTH;
  localparam int P  = 2 * W;
  localparam int CW = $clog2(W + 1);

  rna_pkg::state_t state_r, state_nxt;
  logic [2:0]   act_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;

  // Shift-add multiplier
  logic [P-1:0]  mcand_r;
  logic [W-1:0]  mplier_r;
  logic [P-1:0]  acc_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    msel_r;
  logic [P-1:0]  p0_r, p1_r;

  // Restoring divider over magnitudes
  logic [W-1:0] dvd_r, dvs_r, quo_r, rem_r;
  logic         qneg_r, rneg_r;
  logic [W-1:0] gx_r, gy_r;          // Euclid operands (signed)
  logic [W:0]   qn_r;

  logic [63:0]  res_n_r, res_d_r;
  logic         res_f_r;
  logic         out_valid_r;

  logic accept;
  assign accept = start && !busy;

  function automatic logic [P-1:0] sx(input logic [W-1:0] v);
    sx = {{W{v[W-1]}}, v};
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [63:0] sx64(input logic [P-1:0] v);
    sx64 = 64'($signed(v));
  endfunction

  function automatic logic [63:0] sxw64(input logic [W-1:0] v);
    sxw64 = 64'($signed(v));
  endfunction

  function automatic logic [63:0] sxq64(input logic [W:0] v);
    sxq64 = 64'($signed(v));
  endfunction

  // Divider step values
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;
  assign rem_sh = {rem_r[W-2:0], dvd_r[W-1]};
  assign trial  = {rem_r, dvd_r[W-1]} - {1'b0, dvs_r};

  // Signed remainder and quotient of the finished division; the quotient
  // keeps one extra bit since the most negative value over -1 is positive
  logic [W-1:0] rem_s;
  logic [W:0]   quo_s;
  assign rem_s = rneg_r ? (~rem_r + 1'b1) : rem_r;
  assign quo_s = qneg_r ? (~{1'b0, quo_r} + 1'b1) : {1'b0, quo_r};

  // Multiplier operand selection per pass
  logic [W-1:0] mx, my;
  always_comb begin
    mx = an_r;
    my = bd_r;
    if (act_r == rna_pkg::ACT_MUL) begin
      unique case (msel_r)
        2'd0:    begin mx = an_r; my = bn_r; end
        default: begin mx = ad_r; my = bd_r; end
      endcase
    end else if (act_r == rna_pkg::ACT_DIV) begin
      unique case (msel_r)
        2'd0:    begin mx = an_r; my = bd_r; end
        default: begin mx = ad_r; my = bn_r; end
      endcase
    end else begin
      unique case (msel_r)
        2'd0:    begin mx = an_r; my = bd_r; end
        2'd1:    begin mx = bn_r; my = ad_r; end
        default: begin mx = ad_r; my = bd_r; end
      endcase
    end
  end

  logic mul_done, div_done;
  assign mul_done = (cnt_r == CW'(W));
  assign div_done = (cnt_r == CW'(W));

  logic two_pass;
  assign two_pass = (act_r == rna_pkg::ACT_MUL) || (act_r == rna_pkg::ACT_DIV);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rna_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == rna_pkg::ACT_NORM)      state_nxt = rna_pkg::ST_GCD_INIT;
          else if (in_action == rna_pkg::ACT_NOP)  state_nxt = rna_pkg::ST_FIN;
          else                                     state_nxt = rna_pkg::ST_MUL0;
        end
      end
      rna_pkg::ST_MUL0: if (mul_done) state_nxt = rna_pkg::ST_MUL1;
      rna_pkg::ST_MUL1: if (mul_done) state_nxt = two_pass ? rna_pkg::ST_FIN
                                                          : rna_pkg::ST_MUL2;
      rna_pkg::ST_MUL2: if (mul_done) state_nxt = rna_pkg::ST_COMB;
      rna_pkg::ST_COMB: state_nxt = rna_pkg::ST_FIN;
      rna_pkg::ST_GCD_INIT: begin
        state_nxt = (ad_r == '0) ? rna_pkg::ST_FIN : rna_pkg::ST_DIV;
      end
      rna_pkg::ST_DIV: if (div_done) state_nxt = rna_pkg::ST_GCD_STEP;
      rna_pkg::ST_GCD_STEP: state_nxt = rna_pkg::ST_DIV;
      rna_pkg::ST_QN: if (div_done) state_nxt = rna_pkg::ST_QD;
      rna_pkg::ST_QD: if (div_done) state_nxt = rna_pkg::ST_FIN;
      rna_pkg::ST_FIN: state_nxt = rna_pkg::ST_IDLE;
      default: state_nxt = rna_pkg::ST_IDLE;
    endcase
    // Euclid step branches on the remainder just produced
    if (state_r == rna_pkg::ST_GCD_STEP && rem_r == '0) state_nxt = rna_pkg::ST_QN;
  end

  // Outputs of the control
  always_comb begin
    busy = (state_r != rna_pkg::ST_IDLE);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rna_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == rna_pkg::ST_FIN);
    end
  end

  // Load a division of signed x by signed y
  task automatic load_div(input logic [W-1:0] x, input logic [W-1:0] y);
    dvd_r  <= mag(x);
    dvs_r  <= mag(y);
    qneg_r <= x[W-1] ^ y[W-1];
    rneg_r <= x[W-1];
    rem_r  <= '0;
    quo_r  <= '0;
    cnt_r  <= '0;
  endtask

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      rna_pkg::ST_IDLE: begin
        if (accept) begin
          act_r  <= in_action;
          an_r   <= in_a_numerator[W-1:0];
          ad_r   <= in_a_denominator[W-1:0];
          bn_r   <= in_b_numerator[W-1:0];
          bd_r   <= in_b_denominator[W-1:0];
          msel_r <= 2'd0;
          cnt_r  <= '0;
          acc_r  <= '0;
          mcand_r  <= sx(in_a_numerator[W-1:0]);
          mplier_r <= '0;
          gx_r   <= in_a_numerator[W-1:0];
          gy_r   <= in_a_denominator[W-1:0];
        end
      end
      rna_pkg::ST_MUL0, rna_pkg::ST_MUL1, rna_pkg::ST_MUL2: begin
        // One multiplier bit per cycle; count W = last (sign) bit done
        if (mul_done) begin
          unique case (msel_r)
            2'd0:    p0_r <= acc_r;
            2'd1:    p1_r <= acc_r;
            default: mcand_r <= acc_r;
          endcase
          msel_r <= msel_r + 2'd1;
          cnt_r  <= '0;
          acc_r  <= '0;
        end else begin
          logic [P-1:0] mc;
          logic [W-1:0] mp;
          mc = (cnt_r == '0) ? sx(mx) : mcand_r;
          mp = (cnt_r == '0) ? my : mplier_r;
          if (mp[0]) begin
            if (cnt_r == CW'(W - 1)) acc_r <= acc_r - mc;
            else                     acc_r <= acc_r + mc;
          end
          mcand_r  <= mc << 1;
          mplier_r <= mp >> 1;
          cnt_r    <= cnt_r + 1'b1;
        end
      end
      rna_pkg::ST_COMB: begin
        // mcand_r holds the common denominator here
        logic [P-1:0] xn, yn, cd;
        xn = p0_r;
        yn = p1_r;
        cd = mcand_r;
        if (cd[P-1]) begin
          xn = ~xn + 1'b1;
          yn = ~yn + 1'b1;
          cd = ~cd + 1'b1;
        end
        res_f_r <= 1'b0;
        res_n_r <= '0;
        res_d_r <= '0;
        unique case (act_r)
          rna_pkg::ACT_ADD: begin
            res_n_r <= sx64(xn) + sx64(yn);
            res_d_r <= sx64(cd);
          end
          rna_pkg::ACT_SUB: begin
            res_n_r <= sx64(xn) - sx64(yn);
            res_d_r <= sx64(cd);
          end
          rna_pkg::ACT_EQ: res_f_r <= (xn == yn);
          default:         res_f_r <= ($signed(xn) < $signed(yn));
        endcase
      end
      rna_pkg::ST_GCD_INIT: begin
        if (ad_r != '0) load_div(gx_r, gy_r);
      end
      rna_pkg::ST_DIV, rna_pkg::ST_QN, rna_pkg::ST_QD: begin
        if (!div_done) begin
          if (!trial[W]) begin
            rem_r <= trial[W-1:0];
            quo_r <= {quo_r[W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[W-2:0], 1'b0};
          end
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r + 1'b1;
        end else if (state_r == rna_pkg::ST_QN) begin
          qn_r <= quo_s;
          load_div(ad_r, gy_r);
        end
      end
      rna_pkg::ST_GCD_STEP: begin
        // x <- y; y <- r; stop when r is zero, gcd in gy_r
        if (rem_r != '0) begin
          gx_r <= gy_r;
          gy_r <= rem_s;
          load_div(gy_r, rem_s);
        end else begin
          load_div(an_r, gy_r);
        end
      end
      rna_pkg::ST_FIN: begin
        unique case (act_r)
          rna_pkg::ACT_MUL, rna_pkg::ACT_DIV: begin
            res_n_r <= sx64(p0_r);
            res_d_r <= sx64(p1_r);
            res_f_r <= 1'b0;
          end
          rna_pkg::ACT_NORM: begin
            if (ad_r == '0) begin
              res_n_r <= sxw64(an_r);
              res_d_r <= '0;
              res_f_r <= 1'b0;
            end else if (quo_s[W]) begin
              res_n_r <= -sxq64(qn_r);
              res_d_r <= -sxq64(quo_s);
              res_f_r <= 1'b1;
            end else begin
              res_n_r <= sxq64(qn_r);
              res_d_r <= sxq64(quo_s);
              res_f_r <= 1'b1;
            end
          end
          rna_pkg::ACT_NOP: begin
            res_n_r <= '0;
            res_d_r <= '0;
            res_f_r <= 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid              = out_valid_r;
  assign out_result_numerator   = res_n_r;
  assign out_result_denominator = res_d_r;
  assign out_flag               = res_f_r;

endmodule

/* hdl/rna_checker.sv */
// ----------------------------------------------------------------------------
// rna_checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
module rna_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_flag,
  input logic [63:0] out_result_denominator
);

  // A transfer always raises busy
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after transfer");

  // A result ends the command
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // A result is one cycle long
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // Result only follows a busy period
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy)) else $error("result without command");

  // A set flag comes with a zero or positive denominator
  a_flag_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag |-> !out_result_denominator[63])
    else $error("negative denominator with flag set");

endmodule

bind rational_number_alu_top rna_checker u_rna_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .start                  (start),
  .busy                   (busy),
  .out_valid              (out_valid),
  .out_flag               (out_flag),
  .out_result_denominator (out_result_denominator)
);
